[hw/rtl/ffua_pkg.sv]
// Package for the first-fit unit allocator: request and response payload types,
// mode codes, counter limits and the controller/datapath command and status types.
// Depends on nothing.
package ffua_pkg;

    // Request modes. The unused code behaves as a query.
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // Saturation limit of the 11-bit running counters.
    localparam logic [10:0] COUNT_MAX = 11'd2047;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  owner_id;
        logic [10:0] unit_count;
    } ffua_req_t;

    typedef struct packed {
        logic        success;
        logic [9:0]  start_unit;
        logic [10:0] free_units;
        logic [10:0] allocated_total;
        logic [10:0] resident_count;
    } ffua_rsp_t;

    // Datapath operation selected by the controller.
    typedef enum logic [2:0] {
        DP_IDLE,
        DP_CLEAR,
        DP_ALLOC_SCAN,
        DP_ALLOC_FILL,
        DP_FREE_SCAN
    } ffua_op_t;

    typedef struct packed {
        ffua_op_t op;
        logic     capture;
        logic     finish;
    } ffua_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic alloc_hit;
        logic alloc_miss;
        logic fill_done;
        logic free_done;
        logic out_room;
        logic new_alloc;
        logic new_free;
        logic new_size_zero;
    } ffua_status_t;

endpackage

[hw/rtl/first_fit_unit_allocator.sv]
// Top level of the first-fit unit allocator: controller plus datapath.
// Depends on ffua_pkg, ffua_ctrl, ffua_datapath and ffua_ram.
//
// A request (mode, owner_id, unit_count) enters on req_valid/req_ready and one
// response leaves on rsp_valid/rsp_ready for every request. Allocate scans the
// unit map from unit 0 for the first free run of unit_count units; free clears
// the owner's units lowest first; query only reports the counters.
// After reset a clearing pass writes every map entry with req_ready low; the
// running counters start at zero. The single map RAM read port sees one unit
// per cycle while a scan runs. Query and zero-size requests skip the scan; a
// free scans the map, and an allocate scans it and then writes the run. One
// request is worked on at a time. The response sits in an output register, so
// a new request is taken while the previous response waits; a stalled receiver
// holds the finished result of the next request until the register frees up.
module first_fit_unit_allocator
    import ffua_pkg::*;
#(
    parameter int MEMORY_UNITS = 1024,
    parameter int OWNER_BITS   = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  ffua_req_t req_data,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output ffua_rsp_t rsp_data
);

    ffua_cmd_t    cmd;
    ffua_status_t status;

    ffua_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ffua_datapath #(
        .MEMORY_UNITS (MEMORY_UNITS),
        .OWNER_BITS   (OWNER_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .rsp_data  (rsp_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[hw/rtl/ffua_ram.sv]
// Generic simple dual-port RAM: one write port and one read port with registered data.
// Depends on nothing.
module ffua_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/ffua_ctrl.sv]
// Controller state machine of the first-fit unit allocator.
// Depends on ffua_pkg; drives the datapath through ffua_cmd_t and reads ffua_status_t.
module ffua_ctrl
    import ffua_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  ffua_status_t status,
    output ffua_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_FILL,
        S_FREE,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   req_ready_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next  = state_reg;
        cmd.op      = DP_IDLE;
        cmd.capture = 1'b0;
        cmd.finish  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = DP_CLEAR;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid && req_ready_reg)
                begin
                    cmd.capture = 1'b1;
                    if (status.new_size_zero)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (status.new_alloc)
                    begin
                        state_next = S_ALLOC;
                    end
                    else if (status.new_free)
                    begin
                        state_next = S_FREE;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_ALLOC:
            begin
                cmd.op = DP_ALLOC_SCAN;
                if (status.alloc_hit)
                begin
                    state_next = S_FILL;
                end
                else if (status.alloc_miss)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FILL:
            begin
                cmd.op = DP_ALLOC_FILL;
                if (status.fill_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FREE:
            begin
                cmd.op = DP_FREE_SCAN;
                if (status.free_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (status.out_room)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // State register and registered ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            req_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign req_ready = req_ready_reg;

endmodule

[hw/rtl/ffua_datapath.sv]
// Datapath of the first-fit unit allocator: unit map RAM, scan and fill counters,
// running counters and the response register.
// Depends on ffua_pkg and ffua_ram.
module ffua_datapath
    import ffua_pkg::*;
#(
    parameter int MEMORY_UNITS = 1024,
    parameter int OWNER_BITS   = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  ffua_req_t    req_data,
    output ffua_rsp_t    rsp_data,
    output logic         rsp_valid,
    input  logic         rsp_ready,
    input  ffua_cmd_t    cmd,
    output ffua_status_t status
);

    localparam int AW  = $clog2(MEMORY_UNITS);
    localparam int AW1 = AW + 1;
    localparam int CW  = (AW1 > 11) ? AW1 : 11;
    localparam int WW  = OWNER_BITS + 1;
    localparam logic [AW-1:0] LAST  = AW'(MEMORY_UNITS - 1);
    localparam logic [AW:0]   UNITS = AW1'(MEMORY_UNITS);

    // Request and scan registers.
    ffua_req_t           req_reg;
    logic [AW-1:0]       rd_addr_reg,   rd_addr_next;
    logic [AW-1:0]       dat_addr_reg;
    logic                dat_valid_reg, dat_valid_next;
    logic [AW-1:0]       wr_addr_reg,   wr_addr_next;
    logic [CW-1:0]       run_reg,       run_next;
    logic [AW-1:0]       run_start_reg, run_start_next;
    logic [CW-1:0]       cleared_reg,   cleared_next;
    logic                ok_reg,        ok_next;

    // Running counters and the response register.
    logic [AW:0]         used_count_reg, used_count_next;
    logic [10:0]         alloc_reg,      alloc_next;
    logic [10:0]         resident_reg,   resident_next;
    logic                rsp_valid_reg,  rsp_valid_next;
    ffua_rsp_t           rsp_data_reg,   rsp_data_next;

    // RAM ports.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WW-1:0]       ram_wdata;
    logic                ram_re;
    logic [WW-1:0]       ram_rdata;

    logic [OWNER_BITS-1:0] owner_q;
    logic [CW-1:0]       size_c;
    logic                used_rd;
    logic [OWNER_BITS-1:0] owner_rd;
    logic [CW-1:0]       run_inc;
    logic [CW-1:0]       cleared_inc;
    logic                free_match;
    logic                scan_last;

    logic [11:0]         alloc_sum;
    logic [10:0]         alloc_add;
    logic [10:0]         alloc_sub;
    logic [10:0]         res_add;
    logic [10:0]         res_sub;
    logic [AW:0]         used_delta;
    logic [CW-1:0]       free_w;
    logic [CW-1:0]       start_w;

    ffua_ram #(
        .WIDTH (WW),
        .DEPTH (MEMORY_UNITS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // Fields of the current request and of the unit under test.
    assign owner_q     = OWNER_BITS'(req_reg.owner_id);
    assign size_c      = CW'(req_reg.unit_count);
    assign used_rd     = ram_rdata[OWNER_BITS];
    assign owner_rd    = ram_rdata[OWNER_BITS-1:0];
    assign run_inc     = run_reg + CW'(1);
    assign cleared_inc = cleared_reg + CW'(1);
    assign scan_last   = dat_valid_reg && (dat_addr_reg == LAST);
    assign free_match  = (cmd.op == DP_FREE_SCAN) && dat_valid_reg && used_rd
                         && (owner_rd == owner_q) && (cleared_reg < size_c);

    // Status toward the controller.
    always_comb
    begin
        status.clear_done    = (cmd.op == DP_CLEAR) && (wr_addr_reg == LAST);
        status.alloc_hit     = (cmd.op == DP_ALLOC_SCAN) && dat_valid_reg && !used_rd
                               && (run_inc == size_c);
        status.alloc_miss    = (cmd.op == DP_ALLOC_SCAN) && scan_last && !status.alloc_hit;
        status.fill_done     = (cmd.op == DP_ALLOC_FILL) && (cleared_inc == size_c);
        status.free_done     = (cmd.op == DP_FREE_SCAN) && dat_valid_reg
                               && (scan_last || (free_match && (cleared_inc == size_c)));
        status.out_room      = !rsp_valid_reg || rsp_ready;
        status.new_alloc     = (req_data.mode == MODE_ALLOC);
        status.new_free      = (req_data.mode == MODE_FREE);
        status.new_size_zero = ((req_data.mode == MODE_ALLOC) || (req_data.mode == MODE_FREE))
                               && (req_data.unit_count == 11'd0);
    end

    // RAM write and read control for each operation.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        case (cmd.op)
            DP_CLEAR:
            begin
                ram_we = 1'b1;
            end
            DP_ALLOC_SCAN:
            begin
                ram_re = 1'b1;
            end
            DP_ALLOC_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, owner_q};
            end
            DP_FREE_SCAN:
            begin
                ram_re    = 1'b1;
                ram_we    = free_match;
                ram_waddr = dat_addr_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Scan, run and fill bookkeeping.
    always_comb
    begin
        rd_addr_next   = rd_addr_reg;
        dat_valid_next = 1'b0;
        wr_addr_next   = wr_addr_reg;
        run_next       = run_reg;
        run_start_next = run_start_reg;
        cleared_next   = cleared_reg;
        ok_next        = ok_reg;
        if (cmd.capture)
        begin
            rd_addr_next   = '0;
            run_next       = '0;
            run_start_next = '0;
            cleared_next   = '0;
            ok_next        = 1'b1;
        end
        else
        begin
            case (cmd.op)
                DP_CLEAR:
                begin
                    wr_addr_next = wr_addr_reg + AW'(1);
                end
                DP_ALLOC_SCAN:
                begin
                    dat_valid_next = 1'b1;
                    if (rd_addr_reg != LAST)
                    begin
                        rd_addr_next = rd_addr_reg + AW'(1);
                    end
                    if (dat_valid_reg)
                    begin
                        if (!used_rd)
                        begin
                            run_next = run_inc;
                            if (run_reg == '0)
                            begin
                                run_start_next = dat_addr_reg;
                            end
                        end
                        else
                        begin
                            run_next = '0;
                        end
                    end
                    if (status.alloc_hit)
                    begin
                        wr_addr_next = (run_reg == '0) ? dat_addr_reg : run_start_reg;
                        cleared_next = '0;
                    end
                    if (status.alloc_miss)
                    begin
                        ok_next = 1'b0;
                    end
                end
                DP_ALLOC_FILL:
                begin
                    wr_addr_next = wr_addr_reg + AW'(1);
                    cleared_next = cleared_inc;
                end
                DP_FREE_SCAN:
                begin
                    dat_valid_next = 1'b1;
                    if (rd_addr_reg != LAST)
                    begin
                        rd_addr_next = rd_addr_reg + AW'(1);
                    end
                    if (free_match)
                    begin
                        cleared_next = cleared_inc;
                    end
                end
                default:
                begin
                    dat_valid_next = 1'b0;
                end
            endcase
        end
    end

    // Saturating counter arithmetic for the finishing step.
    assign alloc_sum  = {1'b0, alloc_reg} + {1'b0, req_reg.unit_count};
    assign alloc_add  = (alloc_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : alloc_sum[10:0];
    assign alloc_sub  = (alloc_reg > req_reg.unit_count) ? (alloc_reg - req_reg.unit_count)
                                                         : 11'd0;
    assign res_add    = (resident_reg == COUNT_MAX) ? COUNT_MAX : (resident_reg + 11'd1);
    assign res_sub    = (resident_reg != 11'd0) ? (resident_reg - 11'd1) : 11'd0;
    assign used_delta = cleared_reg[AW:0];

    // Counter update and response assembly.
    always_comb
    begin
        used_count_next = used_count_reg;
        alloc_next      = alloc_reg;
        resident_next   = resident_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_data_next   = rsp_data_reg;
        if (cmd.finish)
        begin
            case (req_reg.mode)
                MODE_ALLOC:
                begin
                    if (ok_reg)
                    begin
                        used_count_next = used_count_reg + used_delta;
                        alloc_next      = alloc_add;
                        resident_next   = res_add;
                    end
                end
                MODE_FREE:
                begin
                    used_count_next = used_count_reg - used_delta;
                    alloc_next      = alloc_sub;
                    resident_next   = res_sub;
                end
                default:
                begin
                    used_count_next = used_count_reg;
                end
            endcase
            rsp_valid_next                = 1'b1;
            rsp_data_next.success         = (req_reg.mode == MODE_ALLOC) ? ok_reg : 1'b1;
            rsp_data_next.start_unit      = ((req_reg.mode == MODE_ALLOC) && ok_reg)
                                            ? start_w[9:0] : 10'd0;
            rsp_data_next.free_units      = free_w[10:0];
            rsp_data_next.allocated_total = alloc_next;
            rsp_data_next.resident_count  = resident_next;
        end
    end

    assign start_w = CW'(run_start_reg);
    assign free_w  = CW'(UNITS - used_count_next);

    // Control and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_addr_reg    <= '0;
            dat_valid_reg  <= 1'b0;
            used_count_reg <= '0;
            alloc_reg      <= '0;
            resident_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            wr_addr_reg    <= wr_addr_next;
            dat_valid_reg  <= dat_valid_next;
            used_count_reg <= used_count_next;
            alloc_reg      <= alloc_next;
            resident_reg   <= resident_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_data;
        end
        rd_addr_reg   <= rd_addr_next;
        dat_addr_reg  <= rd_addr_reg;
        run_reg       <= run_next;
        run_start_reg <= run_start_next;
        cleared_reg   <= cleared_next;
        ok_reg        <= ok_next;
        rsp_data_reg  <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

[verif/ffua_checker.sv]
// Response checker for the first-fit unit allocator: watches both channels,
// predicts every response from its own copy of the unit map and compares.
// Depends on ffua_pkg.
module ffua_checker
    import ffua_pkg::*;
#(
    parameter int MEMORY_UNITS = 1024,
    parameter int OWNER_BITS   = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_ready,
    input  ffua_req_t req_data,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  ffua_rsp_t rsp_data,
    output int        failures,
    output int        outstanding
);

    localparam int OWNER_MASK = (1 << OWNER_BITS) - 1;

    // Shadow copy of the unit map and the running counters.
    bit          map_used [MEMORY_UNITS];
    logic [15:0] map_owner [MEMORY_UNITS];
    int          units_allocated;
    int          resident_allocs;

    // Responses predicted for accepted requests, oldest first.
    ffua_rsp_t   pending_results [$];
    int          mismatch_count = 0;

    assign failures    = mismatch_count;
    assign outstanding = pending_results.size();

    // Add with saturation at the 11-bit counter limit.
    function automatic int bounded_sum(input int a, input int b);
        return (a + b > int'(COUNT_MAX)) ? int'(COUNT_MAX) : a + b;
    endfunction

    // Apply one request to the shadow map and return the response it yields.
    function automatic ffua_rsp_t predict_allocation(input ffua_req_t r);
        ffua_rsp_t rsp;
        int        owner;
        int        size;
        int        run;
        int        run_start;
        int        cleared;
        int        free_count;
        bit        found;
        rsp.success    = 1'b1;
        rsp.start_unit = '0;
        owner = int'(r.owner_id) & OWNER_MASK;
        size  = int'(r.unit_count);
        case (r.mode)
            MODE_ALLOC:
            begin
                if (size == 0) begin
                    resident_allocs = bounded_sum(resident_allocs, 1);
                end
                else begin
                    run       = 0;
                    run_start = 0;
                    found     = 1'b0;
                    // First fit: the earliest run of free units long enough.
                    for (int i = 0; i < MEMORY_UNITS; i++) begin
                        if (!map_used[i]) begin
                            if (run == 0)
                                run_start = i;
                            run++;
                            if (run == size) begin
                                found = 1'b1;
                                break;
                            end
                        end
                        else begin
                            run = 0;
                        end
                    end
                    if (found) begin
                        for (int i = run_start; i < run_start + size; i++) begin
                            map_used[i]  = 1'b1;
                            map_owner[i] = 16'(owner);
                        end
                        rsp.start_unit  = 10'(run_start);
                        units_allocated = bounded_sum(units_allocated, size);
                        resident_allocs = bounded_sum(resident_allocs, 1);
                    end
                    else begin
                        rsp.success = 1'b0;
                    end
                end
            end
            MODE_FREE:
            begin
                // Release the owner's units lowest first, up to the size.
                cleared = 0;
                for (int i = 0; i < MEMORY_UNITS && cleared < size; i++) begin
                    if (map_used[i] && int'(map_owner[i]) == owner) begin
                        map_used[i]  = 1'b0;
                        map_owner[i] = '0;
                        cleared++;
                    end
                end
                units_allocated = (units_allocated > size) ? units_allocated - size : 0;
                resident_allocs = (resident_allocs > 1) ? resident_allocs - 1 : 0;
            end
            default:
            begin
                // Query and the spare code leave the state alone.
            end
        endcase
        free_count = 0;
        for (int i = 0; i < MEMORY_UNITS; i++)
            if (!map_used[i])
                free_count++;
        rsp.free_units      = 11'(free_count);
        rsp.allocated_total = 11'(units_allocated);
        rsp.resident_count  = 11'(resident_allocs);
        return rsp;
    endfunction

    // Compare one response field and count a mismatch.
    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
            mismatch_count++;
        end
    endtask

    // Retire responses against predictions, then record new requests.
    always @(posedge clk or negedge rst_n)
    begin
        ffua_rsp_t want;
        if (!rst_n) begin
            pending_results.delete();
            for (int i = 0; i < MEMORY_UNITS; i++) begin
                map_used[i]  = 1'b0;
                map_owner[i] = '0;
            end
            units_allocated = 0;
            resident_allocs = 0;
        end
        else begin
            if (rsp_valid && rsp_ready) begin
                if (pending_results.size() == 0) begin
                    $error("response arrived with no request outstanding");
                    mismatch_count++;
                end
                else begin
                    want = pending_results.pop_front();
                    check_field("success", want.success, rsp_data.success);
                    check_field("start_unit", want.start_unit, rsp_data.start_unit);
                    check_field("free_units", want.free_units, rsp_data.free_units);
                    check_field("allocated_total", want.allocated_total,
                                rsp_data.allocated_total);
                    check_field("resident_count", want.resident_count,
                                rsp_data.resident_count);
                end
            end
            if (req_valid && req_ready)
                pending_results.push_back(predict_allocation(req_data));
        end
    end

endmodule

[verif/testbench.sv]
// Top of the allocator testbench: clock, reset, request stimulus, response
// back-pressure and the final verdict. Depends on ffua_pkg, ffua_checker and
// first_fit_unit_allocator.
module testbench;
    import ffua_pkg::*;

    localparam int UNITS   = 1024;
    localparam int OWNER_W = 8;

    // The fourth mode code is not named in the package; it acts as a query.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    ffua_req_t req_data  = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    ffua_rsp_t rsp_data;
    int        failures;
    int        outstanding;
    bit        steady     = 1'b1;
    int        stall_left = 0;

    first_fit_unit_allocator #(
        .MEMORY_UNITS(UNITS),
        .OWNER_BITS  (OWNER_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data (rsp_data)
    );

    ffua_checker #(
        .MEMORY_UNITS(UNITS),
        .OWNER_BITS  (OWNER_W)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_data   (rsp_data),
        .failures   (failures),
        .outstanding(outstanding)
    );

    // Free-running clock, period 8.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle length in cycles: mostly short, now and then long.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 16);
        else
            return $urandom_range(40, 150);
    endfunction

    // Present one request, hold it until accepted, then maybe pause.
    task automatic send_request(input logic [1:0] mode, input logic [7:0] owner,
                                input logic [10:0] count);
        ffua_req_t item;
        int        gap;
        item.mode       = mode;
        item.owner_id   = owner;
        item.unit_count = count;
        req_valid <= 1'b1;
        req_data  <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        gap = (steady || $urandom_range(0, 99) < 55) ? 0 : idle_length();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Response back-pressure: random stalls except during steady stretches.
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!steady && $urandom_range(0, 99) < 20) begin
            rsp_ready  <= 1'b0;
            stall_left <= idle_length() - 1;
        end
        else begin
            rsp_ready <= 1'b1;
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int          pick;
        int          grade;
        logic [7:0]  owner;
        logic [10:0] size;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests: reset state, size extremes, holes and owner zero.
        send_request(MODE_QUERY, 8'd0, 11'd0);
        send_request(MODE_SPARE, 8'hFF, 11'h7FF);
        send_request(MODE_ALLOC, 8'd5, 11'd0);
        send_request(MODE_FREE, 8'd5, 11'd0);
        send_request(MODE_FREE, 8'd5, 11'd0);
        send_request(MODE_ALLOC, 8'hFF, 11'h7FF);
        send_request(MODE_ALLOC, 8'd9, 11'd1025);
        send_request(MODE_ALLOC, 8'hAA, 11'd1024);
        send_request(MODE_ALLOC, 8'd1, 11'd1);
        send_request(MODE_FREE, 8'hAA, 11'h7FF);
        send_request(MODE_ALLOC, 8'd0, 11'd10);
        send_request(MODE_ALLOC, 8'h55, 11'd20);
        send_request(MODE_ALLOC, 8'd0, 11'd5);
        send_request(MODE_FREE, 8'd0, 11'd3);
        send_request(MODE_FREE, 8'd0, 11'd100);
        send_request(MODE_ALLOC, 8'd7, 11'd3);
        send_request(MODE_ALLOC, 8'd7, 11'd12);
        send_request(MODE_FREE, 8'hFF, 11'd4);
        send_request(MODE_QUERY, 8'h55, 11'h555);
        send_request(MODE_FREE, 8'h55, 11'd20);
        send_request(MODE_FREE, 8'd7, 11'h7FF);

        // Random traffic: mostly allocate and free for a small owner pool.
        for (int n = 0; n < 560; n++) begin
            if (n % 40 == 0)
                steady <= ($urandom_range(0, 3) == 0);
            pick  = $urandom_range(0, 99);
            grade = $urandom_range(0, 99);
            owner = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 6));
            if (pick < 45) begin
                if (grade < 5)
                    size = '0;
                else if (grade < 80)
                    size = 11'($urandom_range(1, 48));
                else if (grade < 95)
                    size = 11'($urandom_range(49, 300));
                else if (grade < 98)
                    size = 11'($urandom_range(301, 1024));
                else
                    size = 11'($urandom_range(1025, 2047));
                send_request(MODE_ALLOC, owner, size);
            end
            else if (pick < 80) begin
                if (grade < 10)
                    size = '0;
                else if (grade < 60)
                    size = 11'($urandom_range(1, 64));
                else if (grade < 90)
                    size = 11'($urandom_range(65, 400));
                else
                    size = 11'h7FF;
                send_request(MODE_FREE, owner, size);
            end
            else if (pick < 92) begin
                send_request(MODE_QUERY, owner, 11'($urandom_range(0, 2047)));
            end
            else if (pick < 95) begin
                send_request(MODE_SPARE, owner, 11'($urandom_range(0, 2047)));
            end
            else begin
                send_request((grade < 50) ? MODE_ALLOC : MODE_FREE,
                             8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
            end
        end

        // Close with a few zero-size frees and a final query.
        steady <= 1'b0;
        for (int n = 0; n < 3; n++)
            send_request(MODE_FREE, 8'($urandom_range(0, 255)), 11'd0);
        send_request(MODE_QUERY, 8'd0, 11'd0);
        req_valid <= 1'b0;

        // Drain, then allow one full scan more for anything stray.
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (UNITS + 16) @(posedge clk);
        @(negedge clk);
        if (failures == 0)
            $display("first_fit_unit_allocator test passed");
        else
            $display("first_fit_unit_allocator test failed");
        $finish;
    end

    // Hard limit on the run time.
    initial
    begin
        #400_000_000;
        $display("first_fit_unit_allocator test failed");
        $finish;
    end

endmodule
